// ===== sv/sorted_list_insert_and_readout_defines.svh =====
// Assertion macros shared by the sorted list RTL
`ifndef SORTED_LIST_INSERT_AND_READOUT_DEFINES_SVH
`define SORTED_LIST_INSERT_AND_READOUT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SLI_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list assertion failed");

// Next-cycle implication, checked outside reset
`define SLI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list assertion failed");

`endif

// ===== sv/sli_pkg.sv =====
// Shared constants, codes and types of the sorted list block
package sli_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_READ_FWD = 2'd1;
  localparam logic [1:0] OP_READ_REV = 2'd2;

  // order modes
  localparam logic [1:0] MODE_ASC  = 2'd1;
  localparam logic [1:0] MODE_DESC = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OFF  = 2'd2;

  // values reported for an empty list
  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // comparator result: a below b, a above b
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

// ===== sv/sli_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sli_cmp.sv =====
// Shared signed magnitude comparator used by the insert search
module sli_cmp
  import sli_pkg::*;
(
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output cmp_res_t                 res
);

  assign res.lt = (a < b);
  assign res.gt = (a > b);

endmodule

// ===== sv/sorted_list_insert_and_readout.sv =====
// Top level of the sorted list: sequencer, entry RAM and output register
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid / in_ready    | operation, new_value
//  out     | output    | out_valid / out_ready  | item, head, tail, last, empty, status
//  cfg     | input     | cfg_we (no wait)       | order mode
//
// While an insert is in progress in_ready stays low: the scan reads the entries up to
// the slot, every entry from the slot upward is moved one place up, then the value is
// written and the result loaded. Ignored inserts, unused ops and readouts of an empty
// list go straight from idle to the result word.
// A readout gives one word per cycle while out_ready is high; the RAM read data is registered.
// rst_n is synchronous; the RAM is not cleared, the entry count is.
// in_ready is high only while the sequencer is idle; a stalled out word
// holds the sequencer in its emitting state.
module sorted_list_insert_and_readout
  import sli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_operation,
  input  logic signed [DATA_W-1:0] in_new_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_item_value,
  output logic signed [DATA_W-1:0] out_head_value,
  output logic signed [DATA_W-1:0] out_tail_value,
  output logic                     out_last_of_run,
  output logic                     out_list_empty,
  output logic [1:0]               out_status,
  // configuration
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_wdata
);

`include "sorted_list_insert_and_readout_defines.svh"

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [1:0]               order_mode_r;
  logic signed [DATA_W-1:0] head_r, head_nxt;
  logic signed [DATA_W-1:0] tail_r, tail_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     asc_r, asc_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [AW-1:0]            ni_r, ni_nxt;
  cmp_res_t                 prev_r, prev_nxt;
  logic [AW-1:0]            sa_r, sa_nxt;
  logic [AW-1:0]            wa_r, wa_nxt;
  logic                     iss_r, iss_nxt;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     fwd_r, fwd_nxt;
  logic [1:0]               status_r, status_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_item_r, out_item_nxt;
  logic signed [DATA_W-1:0] out_head_r, out_head_nxt;
  logic signed [DATA_W-1:0] out_tail_r, out_tail_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic [1:0]               out_status_r, out_status_nxt;

  // RAM and comparator hookup
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0] cmp_a, cmp_b;
  cmp_res_t                 cmp_res;

  logic                     out_load;
  logic                     mode_on;
  logic                     is_empty;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            cnt_last_a;
  logic                     match;
  logic                     rd_last;

  sli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sli_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // comparator operands: head on accept, streamed entry during the scan
  assign cmp_a = (state_r == S_IDLE) ? in_new_value : val_r;
  assign cmp_b = (state_r == S_IDLE) ? head_r : $signed(ram_rdata);

  assign in_ready   = (state_r == S_IDLE);
  assign out_load   = !out_valid_r || out_ready;
  assign mode_on    = (order_mode_r == MODE_ASC) || (order_mode_r == MODE_DESC);
  assign is_empty   = (count_r == '0);
  assign cnt_m1     = count_r - CW'(1);
  assign cnt_last_a = cnt_m1[AW-1:0];
  // new value sits between previous entry and the one just read
  assign match      = asc_r ? (!prev_r.lt && cmp_res.lt) : (!prev_r.gt && cmp_res.gt);
  assign rd_last    = fwd_r ? (CW'(idx_r) == cnt_m1) : (idx_r == '0);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    val_nxt        = val_r;
    asc_nxt        = asc_r;
    pos_nxt        = pos_r;
    ni_nxt         = ni_r;
    prev_nxt       = prev_r;
    sa_nxt         = sa_r;
    wa_nxt         = wa_r;
    iss_nxt        = iss_r;
    pend_nxt       = pend_r;
    idx_nxt        = idx_r;
    fwd_nxt        = fwd_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    out_head_nxt   = out_head_r;
    out_tail_nxt   = out_tail_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_DONE;
          case (in_operation)
            OP_INSERT: begin
              if (!mode_on) begin
                status_nxt = ST_OFF;
                state_nxt  = S_RES;
              end else if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RES;
              end else begin
                val_nxt = in_new_value;
                asc_nxt = (order_mode_r == MODE_ASC);
                if (is_empty) begin
                  pos_nxt   = '0;
                  state_nxt = S_PUT;
                end else if ((order_mode_r == MODE_ASC) ? cmp_res.lt : cmp_res.gt) begin
                  // new head: move every entry up by one
                  pos_nxt   = '0;
                  sa_nxt    = cnt_last_a;
                  iss_nxt   = 1'b1;
                  pend_nxt  = 1'b0;
                  state_nxt = S_SHIFT;
                end else if (count_r == CW'(1)) begin
                  pos_nxt   = AW'(1);
                  state_nxt = S_PUT;
                end else begin
                  // scan pairs starting with entries 0 and 1
                  prev_nxt  = cmp_res;
                  ram_re    = 1'b1;
                  ram_raddr = AW'(1);
                  ni_nxt    = AW'(1);
                  state_nxt = S_SRCH;
                end
              end
            end
            OP_READ_FWD, OP_READ_REV: begin
              if (is_empty) begin
                state_nxt = S_RES;
              end else begin
                fwd_nxt   = (in_operation == OP_READ_FWD);
                idx_nxt   = (in_operation == OP_READ_FWD) ? '0 : cnt_last_a;
                ram_re    = 1'b1;
                ram_raddr = idx_nxt;
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end

      // one entry per cycle through the comparator
      S_SRCH: begin
        if (match) begin
          pos_nxt   = ni_r;
          sa_nxt    = cnt_last_a;
          iss_nxt   = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else if (CW'(ni_r) == cnt_m1) begin
          pos_nxt   = count_r[AW-1:0];
          state_nxt = S_PUT;
        end else begin
          prev_nxt  = cmp_res;
          ram_re    = 1'b1;
          ram_raddr = ni_r + AW'(1);
          ni_nxt    = ni_r + AW'(1);
        end
      end

      // read entry sa, write it one place up in the following cycle
      S_SHIFT: begin
        ram_we    = pend_r;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
        if (iss_r) begin
          ram_re    = 1'b1;
          ram_raddr = sa_r;
          wa_nxt    = sa_r + AW'(1);
          pend_nxt  = 1'b1;
          if (sa_r == pos_r) begin
            iss_nxt = 1'b0;
          end else begin
            sa_nxt = sa_r - AW'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_PUT;
        end
      end

      // write the new value and track head and tail
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        if (pos_r == '0) begin
          head_nxt = val_r;
        end
        if (CW'(pos_r) == count_r) begin
          tail_nxt = val_r;
        end
        count_nxt = count_r + CW'(1);
        state_nxt = S_RES;
      end

      // single result word
      S_RES: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '0;
          out_head_nxt   = is_empty ? INT_MIN : head_r;
          out_tail_nxt   = is_empty ? INT_MAX : tail_r;
          out_last_nxt   = 1'b1;
          out_empty_nxt  = is_empty;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      // readout: one word per cycle while the out word is not stalled, next read issued with each load
      S_RD: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = $signed(ram_rdata);
          out_head_nxt   = head_r;
          out_tail_nxt   = tail_r;
          out_last_nxt   = rd_last;
          out_empty_nxt  = 1'b0;
          out_status_nxt = ST_DONE;
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = fwd_r ? (idx_r + AW'(1)) : (idx_r - AW'(1));
            ram_re    = 1'b1;
            ram_raddr = idx_nxt;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      order_mode_r <= MODE_ASC;
      out_valid_r  <= 1'b0;
      iss_r        <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      if (cfg_we) begin
        order_mode_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    val_r        <= val_nxt;
    asc_r        <= asc_nxt;
    pos_r        <= pos_nxt;
    ni_r         <= ni_nxt;
    prev_r       <= prev_nxt;
    sa_r         <= sa_nxt;
    wa_r         <= wa_nxt;
    idx_r        <= idx_nxt;
    fwd_r        <= fwd_nxt;
    status_r     <= status_nxt;
    out_item_r   <= out_item_nxt;
    out_head_r   <= out_head_nxt;
    out_tail_r   <= out_tail_nxt;
    out_last_r   <= out_last_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_item_value  = out_item_r;
  assign out_head_value  = out_head_r;
  assign out_tail_value  = out_tail_r;
  assign out_last_of_run = out_last_r;
  assign out_list_empty  = out_empty_r;
  assign out_status      = out_status_r;

  // checks
  `SLI_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(CAPACITY))
  `SLI_ASSERT_NOW(a_no_write_idle, state_r == S_IDLE || state_r == S_RES || state_r == S_RD, !ram_we)
  `SLI_ASSERT_NEXT(a_count_only_put, state_r != S_PUT, count_r == $past(count_r))
  `SLI_ASSERT_NOW(a_readout_nonempty, state_r == S_RD, count_r != '0)

endmodule

// ===== tb/sorted_list_checker.sv =====
// Checker for the sorted list: shadow store, queue of expected result words, compare
module sorted_list_checker
  import sli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               in_operation,
  input  logic signed [DATA_W-1:0] in_new_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] out_item_value,
  input  logic signed [DATA_W-1:0] out_head_value,
  input  logic signed [DATA_W-1:0] out_tail_value,
  input  logic                     out_last_of_run,
  input  logic                     out_list_empty,
  input  logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_wdata,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // one result word as seen on the out channel
  typedef struct packed {
    logic [DATA_W-1:0] item;
    logic [DATA_W-1:0] head;
    logic [DATA_W-1:0] tail;
    logic              last;
    logic              empty;
    logic [1:0]        status;
  } list_word_t;

  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_count;
  logic [1:0]               shadow_mode;
  list_word_t               expected_words [$];
  int                       mismatches = 0;

  assign fail_count = mismatches;

  // queue a word built from the current shadow state
  function automatic void push_word(input logic [DATA_W-1:0] item, input logic last,
                                    input logic [1:0] status);
    list_word_t w;
    w.item   = item;
    w.last   = last;
    w.status = status;
    w.empty  = (shadow_count == 0);
    w.head   = w.empty ? INT_MIN : shadow_entries[0];
    w.tail   = w.empty ? INT_MAX : shadow_entries[shadow_count - 1];
    expected_words.push_back(w);
  endfunction

  // slot for a new value; no re-sort after a mode change, so scan pairwise
  function automatic int insert_slot(input logic signed [DATA_W-1:0] value, input bit asc);
    if (shadow_count == 0) return 0;
    if (asc ? (value < shadow_entries[0]) : (value > shadow_entries[0])) return 0;
    for (int i = 0; i + 1 < shadow_count; i++) begin
      if (asc ? (value >= shadow_entries[i] && value < shadow_entries[i + 1])
              : (value <= shadow_entries[i] && value > shadow_entries[i + 1]))
        return i + 1;
    end
    return shadow_count;
  endfunction

  // apply one accepted word to the shadow store and queue its results
  function automatic void predict_words(input logic [1:0] op,
                                        input logic signed [DATA_W-1:0] value);
    int slot;
    case (op)
      OP_INSERT: begin
        // off (including mode three) wins over full
        if (shadow_mode != MODE_ASC && shadow_mode != MODE_DESC) begin
          push_word('0, 1'b1, ST_OFF);
        end else if (shadow_count >= CAPACITY) begin
          push_word('0, 1'b1, ST_FULL);
        end else begin
          slot = insert_slot(value, shadow_mode == MODE_ASC);
          for (int j = shadow_count; j > slot; j--)
            shadow_entries[j] = shadow_entries[j - 1];
          shadow_entries[slot] = value;
          shadow_count++;
          push_word('0, 1'b1, ST_DONE);
        end
      end
      OP_READ_FWD, OP_READ_REV: begin
        if (shadow_count == 0) begin
          push_word('0, 1'b1, ST_DONE);
        end else begin
          for (int k = 0; k < shadow_count; k++)
            push_word((op == OP_READ_FWD) ? shadow_entries[k]
                                          : shadow_entries[shadow_count - 1 - k],
                      k == shadow_count - 1, ST_DONE);
        end
      end
      // unused opcode: a status word that changes nothing
      default: push_word('0, 1'b1, ST_DONE);
    endcase
  endfunction

  // outputs first (they belong to older words), then config, then the new word
  always @(posedge clk) begin
    list_word_t got;
    list_word_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_mode  = MODE_ASC;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_item_value, out_head_value, out_tail_value,
               out_last_of_run, out_list_empty, out_status};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected word item=%0d head=%0d tail=%0d last=%0b empty=%0b st=%0d",
                     $signed(got.item), $signed(got.head), $signed(got.tail),
                     got.last, got.empty, got.status);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: exp item=%0d head=%0d tail=%0d last=%0b empty=%0b st=%0d",
                       $realtime, $signed(want.item), $signed(want.head),
                       $signed(want.tail), want.last, want.empty, want.status);
              $display("                 got item=%0d head=%0d tail=%0d last=%0b empty=%0b st=%0d",
                       $signed(got.item), $signed(got.head), $signed(got.tail),
                       got.last, got.empty, got.status);
            end
          end
        end
      end
      if (cfg_we)
        shadow_mode = cfg_wdata;
      if (in_valid && in_ready)
        predict_words(in_operation, in_new_value);
    end
    pending <= expected_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the sorted list testbench: clock, reset, stimulus, ready stalls and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  localparam int          ITEMS       = 420;
  // worst item: 32-word readout with each word stalled, plus a send gap;
  // the limit covers 420 such items several times over
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0]  OP_NOP       = 2'd3;
  localparam logic [1:0]  MODE_OFF     = 2'd0;
  localparam logic [1:0]  MODE_OFF_ALT = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_operation = OP_INSERT;
  logic signed [DATA_W-1:0] in_new_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_item_value;
  logic signed [DATA_W-1:0] out_head_value;
  logic signed [DATA_W-1:0] out_tail_value;
  logic                     out_last_of_run;
  logic                     out_list_empty;
  logic [1:0]               out_status;
  logic                     cfg_we = 1'b0;
  logic [1:0]               cfg_wdata = MODE_ASC;

  int                       fail_count;
  int                       pending;
  int unsigned              cycle_count = 0;
  int unsigned              ready_hold = 0;
  bit                       stall_enable = 1'b1;
  logic [1:0]               cur_mode = MODE_ASC;
  int                       stored = 0;
  logic signed [DATA_W-1:0] used_values [$];

  always #5 clk = ~clk;

  sorted_list_insert_and_readout uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_value  (out_item_value),
    .out_head_value  (out_head_value),
    .out_tail_value  (out_tail_value),
    .out_last_of_run (out_last_of_run),
    .out_list_empty  (out_list_empty),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  sorted_list_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item_value  (out_item_value),
    .out_head_value  (out_head_value),
    .out_tail_value  (out_tail_value),
    .out_last_of_run (out_last_of_run),
    .out_list_empty  (out_list_empty),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // receiver stalls: random bursts with out_ready low
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end else if (rst_n && stall_enable && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(1, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // small values, extremes and duplicates so equal keys and order flips matter
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 6) return int'($urandom_range(0, 8)) - 4;
    if (r < 9) begin
      case ($urandom_range(0, 3))
        0:       return INT_MIN;
        1:       return INT_MAX;
        2:       return INT_MIN + 1;
        default: return INT_MAX - 1;
      endcase
    end
    if (r < 13 && used_values.size() != 0)
      return used_values[$urandom_range(0, used_values.size() - 1)];
    return $urandom;
  endfunction

  // inserts dominate until the store fills, readouts after
  function automatic logic [1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (stored < CAPACITY) begin
      if (r < 12) return OP_INSERT;
      if (r < 15) return OP_READ_FWD;
      if (r < 18) return OP_READ_REV;
      return OP_NOP;
    end
    if (r < 3)  return OP_INSERT;
    if (r < 10) return OP_READ_FWD;
    if (r < 17) return OP_READ_REV;
    return OP_NOP;
  endfunction

  function automatic logic [1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return MODE_OFF;
    if (r == 1) return MODE_OFF_ALT;
    if (r < 6)  return MODE_ASC;
    return MODE_DESC;
  endfunction

  // present one word; returns at the edge where it is taken, valid left high
  task automatic send_word(input logic [1:0] op, input logic signed [DATA_W-1:0] value);
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_valid     <= 1'b0;
      in_operation <= 2'($urandom_range(0, 3));
      in_new_value <= $urandom;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_new_value <= value;
    do @(posedge clk); while (!in_ready);
    // track fill level to steer the stimulus
    if (op == OP_INSERT && (cur_mode == MODE_ASC || cur_mode == MODE_DESC)
        && stored < CAPACITY) begin
      stored++;
      used_values.push_back(value);
    end
  endtask

  // drop valid and wait until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !in_ready);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_mode = mode;
  endtask

  initial begin
    int         sent;
    int         phase_len;
    logic [1:0] op;
    sent = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store in the reset mode
    send_word(OP_READ_FWD, 32'h7FFF_FFFF);
    send_word(OP_READ_REV, 32'h8000_0000);
    send_word(OP_NOP, 32'hFFFF_FFFF);
    // extremes and a duplicate in ascending order
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, INT_MAX);
    send_word(OP_INSERT, INT_MIN);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, -1);
    send_word(OP_READ_FWD, 0);
    send_word(OP_READ_REV, 0);
    send_word(OP_NOP, 0);
    // off mode: inserts ignored, readouts still work
    drain();
    set_mode(MODE_OFF);
    send_word(OP_INSERT, 123);
    send_word(OP_READ_FWD, 0);
    // mode three behaves as off
    drain();
    set_mode(MODE_OFF_ALT);
    send_word(OP_INSERT, -5);
    send_word(OP_NOP, 0);
    // flip to descending without re-sorting the store
    drain();
    set_mode(MODE_DESC);
    send_word(OP_INSERT, 1);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, INT_MAX);
    send_word(OP_READ_FWD, 0);
    send_word(OP_READ_REV, 0);

    // random phases, mode rewritten between phases; short phases while filling
    while (sent < ITEMS) begin
      drain();
      stall_enable <= (sent < ITEMS - 60) && ($urandom_range(0, 3) != 0);
      set_mode(pick_mode());
      phase_len = (stored < CAPACITY) ? $urandom_range(3, 10) : $urandom_range(10, 40);
      repeat (phase_len) begin
        op = pick_op();
        send_word(op, (op == OP_INSERT) ? pick_value() : $urandom);
        sent++;
      end
    end

    // full store: dropped inserts, then off taking priority over full
    drain();
    set_mode(MODE_ASC);
    while (stored < CAPACITY)
      send_word(OP_INSERT, pick_value());
    send_word(OP_INSERT, pick_value());
    send_word(OP_READ_FWD, $urandom);
    drain();
    set_mode(MODE_OFF);
    send_word(OP_INSERT, pick_value());
    send_word(OP_READ_REV, $urandom);
    drain();
    set_mode(MODE_DESC);
    send_word(OP_INSERT, pick_value());
    send_word(OP_NOP, $urandom);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sli_pkg.sv
sv/sli_ram.sv
sv/sli_cmp.sv
sv/sorted_list_insert_and_readout.sv
tb/sorted_list_checker.sv
tb/testbench.sv
